### hw/rtl/rcr_pkg.sv
package rcr_pkg;

  // field widths
  localparam int unsigned RefW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ProdW  = 2 * WordW;
  localparam int unsigned AccW   = ProdW + 2;
  localparam int unsigned QShift = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned InDataW = 4 * RefW + WordW;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegGainErrNow   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGainErrPrev  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegGainDrvPrev  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegGainDrvPrev2 = CfgIdxW'(3);

  // control state
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCalc = 2'b10
  } state_e;

  // sequencer steps
  typedef enum logic [3:0] {
    StepMulCos   = 4'd0,
    StepMulSin   = 4'd1,
    StepSubSin   = 4'd2,
    StepSubMeas  = 4'd3,
    StepSatErr   = 4'd4,
    StepMulG0    = 4'd5,
    StepMulG1    = 4'd6,
    StepAccG1    = 4'd7,
    StepAccG2    = 4'd8,
    StepAccG3    = 4'd9,
    StepFinish   = 4'd10
  } step_e;

  localparam logic signed [AccW-1:0] SatMax = AccW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [AccW-1:0] SatMin = -AccW'(64'sh0000_0000_8000_0000);

  // clamp a wide signed value to the signed word range
  function automatic logic signed [WordW-1:0] sat_word(input logic signed [AccW-1:0] x);
    logic signed [WordW-1:0] r;
    if (x > SatMax) begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end else if (x < SatMin) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = x[WordW-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/rotated_current_regulator_unit.sv
// one shared 32x32 multiplier and one 66-bit adder are stepped through six products and
//   their sums by a sequencer
// the input is accepted only when idle; a stalled result word holds the sequencer
//   at its last step until the output register is free
// reset (rst_ni low, asynchronous): gains, previous error and drives cleared to zero
module rotated_current_regulator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rcr_pkg::WordW-1:0]        cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // ref_d [15:0], ref_q [31:16], angle_sine [47:32], angle_cosine [63:48],
  // measured_current [95:64]
  input  logic [rcr_pkg::InDataW-1:0]      s_axis_tdata,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // drive [31:0]
  output logic [rcr_pkg::WordW-1:0]        m_axis_tdata
);

  localparam int unsigned RefW  = rcr_pkg::RefW;
  localparam int unsigned WordW = rcr_pkg::WordW;
  localparam int unsigned ProdW = rcr_pkg::ProdW;
  localparam int unsigned AccW  = rcr_pkg::AccW;

  rcr_pkg::state_e state_q, state_d;
  rcr_pkg::step_e  step_q, step_d;

  logic signed [WordW-1:0] gain0_q, gain1_q, gain2_q, gain3_q;
  logic signed [WordW-1:0] prev_err_q, prev_drv_q, prev2_drv_q;
  logic signed [WordW-1:0] err_q;
  logic signed [RefW-1:0]  ref_d_q, ref_q_q, sine_q, cosine_q;
  logic signed [WordW-1:0] meas_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [WordW-1:0] mul_a, mul_b;
  logic signed [AccW-1:0]  addend;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [WordW-1:0] drive_w;
  logic [WordW-1:0]        out_data_q;
  logic                    out_valid_q;
  logic                    in_fire, out_free, finish;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == rcr_pkg::StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = (state_q == rcr_pkg::StCalc) && (step_q == rcr_pkg::StepFinish)
                         && out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain0_q <= '0;
      gain1_q <= '0;
      gain2_q <= '0;
      gain3_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rcr_pkg::RegGainErrNow:   gain0_q <= cfg_data_i;
        rcr_pkg::RegGainErrPrev:  gain1_q <= cfg_data_i;
        rcr_pkg::RegGainDrvPrev:  gain2_q <= cfg_data_i;
        rcr_pkg::RegGainDrvPrev2: gain3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      rcr_pkg::StIdle: begin
        if (in_fire) begin
          state_d = rcr_pkg::StCalc;
          step_d  = rcr_pkg::StepMulCos;
        end
      end
      rcr_pkg::StCalc: begin
        if (step_q == rcr_pkg::StepFinish) begin
          if (out_free) state_d = rcr_pkg::StIdle;
        end else begin
          step_d = rcr_pkg::step_e'(step_q + 4'd1);
        end
      end
      default: state_d = rcr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcr_pkg::StIdle;
      step_q  <= rcr_pkg::StepMulCos;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // capture of the input word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ref_d_q  <= s_axis_tdata[RefW-1:0];
      ref_q_q  <= s_axis_tdata[2*RefW-1:RefW];
      sine_q   <= s_axis_tdata[3*RefW-1:2*RefW];
      cosine_q <= s_axis_tdata[4*RefW-1:3*RefW];
      meas_q   <= s_axis_tdata[4*RefW+WordW-1:4*RefW];
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      rcr_pkg::StepMulCos: begin
        mul_a = WordW'(cosine_q);
        mul_b = WordW'(ref_d_q);
      end
      rcr_pkg::StepMulSin: begin
        mul_a = WordW'(sine_q);
        mul_b = WordW'(ref_q_q);
      end
      rcr_pkg::StepMulG0: begin
        mul_a = gain0_q;
        mul_b = err_q;
      end
      rcr_pkg::StepMulG1: begin
        mul_a = gain1_q;
        mul_b = prev_err_q;
      end
      rcr_pkg::StepAccG1: begin
        mul_a = gain2_q;
        mul_b = prev_drv_q;
      end
      rcr_pkg::StepAccG2: begin
        mul_a = gain3_q;
        mul_b = prev2_drv_q;
      end
      default: ;
    endcase
  end

  // shared adder
  assign prod_ext = AccW'(prod_q);

  always_comb begin
    addend = '0;
    acc_d  = acc_q;
    case (step_q)
      rcr_pkg::StepMulSin, rcr_pkg::StepMulG1: acc_d = prod_ext;
      rcr_pkg::StepSubSin: begin
        addend = -prod_ext;
        acc_d  = acc_q + addend;
      end
      rcr_pkg::StepSubMeas: begin
        addend = -AccW'(meas_q);
        acc_d  = acc_q + addend;
      end
      rcr_pkg::StepAccG1, rcr_pkg::StepAccG2, rcr_pkg::StepAccG3: begin
        addend = prod_ext;
        acc_d  = acc_q + addend;
      end
      default: ;
    endcase
  end

  assign drive_w = rcr_pkg::sat_word(acc_q >>> rcr_pkg::QShift);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == rcr_pkg::StCalc) begin
      prod_q <= mul_a * mul_b;
      acc_q  <= acc_d;
      if (step_q == rcr_pkg::StepSatErr) err_q <= rcr_pkg::sat_word(acc_q);
    end
  end

  // loop state, updated when the drive is loaded into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q  <= '0;
      prev_drv_q  <= '0;
      prev2_drv_q <= '0;
    end else if (finish) begin
      prev_err_q  <= err_q;
      prev2_drv_q <= prev_drv_q;
      prev_drv_q  <= drive_w;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) out_data_q <= drive_w;
  end

endmodule
